// ===== sv/arp_pkg.sv =====
// Package for the ARP responder and gateway learner: job and result types,
// frame constants and the reply byte selector. No dependencies.
`default_nettype none

package arp_pkg;

  localparam int unsigned ARP_LEN   = 28;
  localparam int unsigned FRAME_LEN = 42;

  localparam logic [4:0] POS_LAST_FILL = 5'(ARP_LEN - 1);
  localparam logic [4:0] POS_SAT       = 5'(ARP_LEN);
  localparam logic [5:0] IDX_LAST      = 6'(FRAME_LEN - 1);

  localparam logic [15:0] OPC_REQUEST = 16'h0001;
  localparam logic [15:0] OPC_REPLY   = 16'h0002;

  localparam logic [1:0] REG_OWN_MAC    = 2'd0;
  localparam logic [1:0] REG_OWN_IP     = 2'd1;
  localparam logic [1:0] REG_GATEWAY_IP = 2'd2;
  localparam logic [1:0] REG_LEARN_EN   = 2'd3;

  localparam logic [31:0] GATEWAY_IP_RST = 32'hC0A8_0101;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_LEARN = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } arp_job_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [47:0] learned_mac;
    logic [31:0] learned_ip;
  } arp_item_t;

  function automatic logic [7:0] mac_b(input logic [47:0] mac, input logic [2:0] k);
    logic [5:0] sh;
    sh = 6'(8 * (5 - int'(k)));
    return mac[sh +: 8];
  endfunction

  function automatic logic [7:0] ip_b(input logic [31:0] ip, input logic [1:0] k);
    logic [4:0] sh;
    sh = 5'(8 * (3 - int'(k)));
    return ip[sh +: 8];
  endfunction

  // Byte idx of the 42-byte Ethernet + ARP reply
  function automatic logic [7:0] reply_byte(input logic [5:0] idx, input logic [47:0] dmac,
                                            input logic [47:0] smac, input logic [31:0] sip,
                                            input logic [31:0] dip);
    logic [5:0] d;
    logic [7:0] b;
    b = 8'h00;
    d = 6'd0;
    if (idx < 6'd6) begin
      b = mac_b(dmac, idx[2:0]);
    end else if (idx < 6'd12) begin
      d = idx - 6'd6;
      b = mac_b(smac, d[2:0]);
    end else if (idx < 6'd22) begin
      case (idx)
        6'd12: b = 8'h08;
        6'd13: b = 8'h06;
        6'd14: b = 8'h00;
        6'd15: b = 8'h01;
        6'd16: b = 8'h08;
        6'd17: b = 8'h00;
        6'd18: b = 8'h06;
        6'd19: b = 8'h04;
        6'd20: b = 8'h00;
        6'd21: b = 8'h02;
        default: b = 8'h00;
      endcase
    end else if (idx < 6'd28) begin
      d = idx - 6'd22;
      b = mac_b(smac, d[2:0]);
    end else if (idx < 6'd32) begin
      d = idx - 6'd28;
      b = ip_b(sip, d[1:0]);
    end else if (idx < 6'd38) begin
      d = idx - 6'd32;
      b = mac_b(dmac, d[2:0]);
    end else begin
      d = idx - 6'd38;
      b = ip_b(dip, d[1:0]);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/arp_if.sv =====
// Valid/ready channel interfaces: received payload, results, register writes.
// No dependencies.
`default_nettype none

interface arp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;
  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface arp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic [47:0] learned_mac;
  logic [31:0] learned_ip;
  modport source (output valid, output kind, output frame_byte, output frame_last,
                  output learned_mac, output learned_ip, input ready);
  modport sink   (input valid, input kind, input frame_byte, input frame_last,
                  input learned_mac, input learned_ip, output ready);
endinterface

interface arp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/arp_rx_parse.sv =====
// Payload parser: byte position, opcode / sender capture and job decision.
// Depends on arp_pkg.
`default_nettype none

module arp_rx_parse import arp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        rx_last,
  input  wire logic        gen_busy,
  input  wire logic [31:0] gateway_ip,
  input  wire logic        learn_en,
  output arp_job_t         job
);

  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] opc_r, opc_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic        complete, accept;

  // a final byte may start a job, so hold it off while a job is still running
  assign complete = pos_r >= POS_LAST_FILL;
  assign in_ready = !gen_busy || !complete;
  assign accept   = in_valid && in_ready;

  always_comb begin
    opc_nxt = opc_r;
    mac_nxt = mac_r;
    ip_nxt  = ip_r;
    pos_nxt = pos_r;
    job     = '0;
    if (accept) begin
      if (pos_r == 5'd6 || pos_r == 5'd7) begin
        opc_nxt = {opc_r[7:0], rx_byte};
      end else if (pos_r >= 5'd8 && pos_r < 5'd14) begin
        mac_nxt = {mac_r[39:0], rx_byte};
      end else if (pos_r >= 5'd14 && pos_r < 5'd18) begin
        ip_nxt = {ip_r[23:0], rx_byte};
      end
      pos_nxt = complete ? POS_SAT : pos_r + 5'd1;
      if (rx_last) begin
        pos_nxt = 5'd0;
        if (complete) begin
          job.mac = mac_r;
          job.ip  = ip_r;
          if (opc_r == OPC_REQUEST) begin
            job.valid = 1'b1;
            job.kind  = KIND_FRAME;
          end else if (opc_r == OPC_REPLY && ip_r == gateway_ip && learn_en) begin
            job.valid = 1'b1;
            job.kind  = KIND_LEARN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
      opc_r <= '0;
      mac_r <= '0;
      ip_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      opc_r <= opc_nxt;
      mac_r <= mac_nxt;
      ip_r  <= ip_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/arp_tx_gen.sv =====
// Result sequencer: holds one job, steps through the reply bytes or the
// learned event, and drives the result register. Depends on arp_pkg.
`default_nettype none

module arp_tx_gen import arp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire arp_job_t    job,
  output logic             busy,
  input  wire logic [47:0] own_mac,
  input  wire logic [31:0] own_ip,
  output logic             out_valid,
  input  wire logic        out_ready,
  output arp_item_t        out_item
);

  logic        act_r, act_nxt;
  logic        kind_r;
  logic [47:0] mac_r;
  logic [31:0] ip_r;
  logic [5:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  arp_item_t   item_r, item_nxt;
  logic        step, done;

  assign busy      = act_r;
  assign out_valid = ov_r;
  assign out_item  = item_r;

  assign step = act_r && (!ov_r || out_ready);
  assign done = (kind_r == KIND_LEARN) || (idx_r == IDX_LAST);

  always_comb begin
    act_nxt  = act_r;
    idx_nxt  = idx_r;
    item_nxt = item_r;
    ov_nxt   = ov_r && !out_ready;
    if (step) begin
      ov_nxt = 1'b1;
      idx_nxt = idx_r + 6'd1;
      if (done) begin
        act_nxt = 1'b0;
      end
      if (kind_r == KIND_LEARN) begin
        item_nxt.kind        = KIND_LEARN;
        item_nxt.frame_byte  = 8'h00;
        item_nxt.frame_last  = 1'b1;
        item_nxt.learned_mac = mac_r;
        item_nxt.learned_ip  = ip_r;
      end else begin
        item_nxt.kind        = KIND_FRAME;
        item_nxt.frame_byte  = reply_byte(idx_r, mac_r, own_mac, own_ip, ip_r);
        item_nxt.frame_last  = idx_r == IDX_LAST;
        item_nxt.learned_mac = '0;
        item_nxt.learned_ip  = '0;
      end
    end
    if (job.valid) begin
      act_nxt = 1'b1;
      idx_nxt = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
      idx_r <= 6'd0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (job.valid) begin
      kind_r <= job.kind;
      mac_r  <= job.mac;
      ip_r   <= job.ip;
    end
  end

endmodule

`default_nettype wire

// ===== sv/arp_responder_and_gateway_learner.sv =====
// Top level: configuration registers, payload parser and result sequencer.
// Depends on arp_pkg, arp_if.sv, arp_rx_parse and arp_tx_gen.
//
//   channel  dir  carries
//   in_ch    in   rx_byte, rx_last          one payload byte per request
//   out_ch   out  kind, frame_byte, ...     reply frame byte or learned event
//   cfg_ch   in   index, data               register write, always ready
//
// One payload byte is taken per cycle, but packet bytes from the 28th on wait
// while an earlier job is still being sent. A request yields 42 result items,
// one per cycle as out_ch drains, from the sequencer behind a single result
// register. Reset is synchronous, active low, and restores register defaults.
`default_nettype none

module arp_responder_and_gateway_learner import arp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  arp_in_if.sink     in_ch,
  arp_out_if.source  out_ch,
  arp_cfg_if.sink    cfg_ch
);

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [31:0] gw_ip_r;
  logic        learn_en_r;
  arp_job_t    job;
  arp_item_t   item;
  logic        busy;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r  <= '0;
      own_ip_r   <= '0;
      gw_ip_r    <= GATEWAY_IP_RST;
      learn_en_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OWN_MAC:    own_mac_r  <= cfg_ch.data;
        REG_OWN_IP:     own_ip_r   <= cfg_ch.data[31:0];
        REG_GATEWAY_IP: gw_ip_r    <= cfg_ch.data[31:0];
        REG_LEARN_EN:   learn_en_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  arp_rx_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .rx_byte    (in_ch.rx_byte),
    .rx_last    (in_ch.rx_last),
    .gen_busy   (busy),
    .gateway_ip (gw_ip_r),
    .learn_en   (learn_en_r),
    .job        (job)
  );

  arp_tx_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .busy      (busy),
    .own_mac   (own_mac_r),
    .own_ip    (own_ip_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (item)
  );

  assign out_ch.kind        = item.kind;
  assign out_ch.frame_byte  = item.frame_byte;
  assign out_ch.frame_last  = item.frame_last;
  assign out_ch.learned_mac = item.learned_mac;
  assign out_ch.learned_ip  = item.learned_ip;

endmodule

`default_nettype wire
